[design/c2p_pkg.sv]
// Shared constants, payload structs and the arctangent table for the
// cartesian-to-polar converter. No dependencies.
`default_nettype none

package c2p_pkg;

    localparam int DATA_WIDTH   = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int PRE_SHIFT    = 14;
    localparam int ANGLE_W      = 16;
    localparam int ANGLE_LIMIT  = 23040;

    // CORDIC datapath: |x| << 14 times gain and sqrt(2) stays below 2^(W+15)
    localparam int CW = DATA_WIDTH + PRE_SHIFT + 3;
    // angle accumulator, degrees in Q.16, sum of table below 2^23
    localparam int ZW = 25;
    // square sum, remainder and root of the digit-by-digit square root
    localparam int NW = 2 * DATA_WIDTH;
    localparam int RW = DATA_WIDTH + 2;

    localparam int PIPE_STAGES = (DATA_WIDTH > CORDIC_STEPS) ? DATA_WIDTH : CORDIC_STEPS;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_OTHER  = 2'd3;

    typedef struct packed {
        logic       x_zero;
        logic       y_pos;
        logic       y_neg;
        logic [1:0] quad;
    } t_c2p_flags;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
    } t_c2p_cordic;

    typedef struct packed {
        logic [NW-1:0]         n;
        logic [RW-1:0]         rem;
        logic [DATA_WIDTH-1:0] root;
    } t_c2p_sqrt;

    typedef struct packed {
        t_c2p_flags  flags;
        t_c2p_cordic cordic;
        t_c2p_sqrt   sqrt;
    } t_c2p_item;

    // atan(2^-i) in degrees, Q.16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_deg_q16(input int idx);
        logic signed [ZW-1:0] val;
        case (idx)
            0:       val = ZW'(2949120);
            1:       val = ZW'(1740967);
            2:       val = ZW'(919879);
            3:       val = ZW'(466945);
            4:       val = ZW'(234379);
            5:       val = ZW'(117304);
            6:       val = ZW'(58666);
            7:       val = ZW'(29335);
            8:       val = ZW'(14668);
            9:       val = ZW'(7334);
            10:      val = ZW'(3667);
            11:      val = ZW'(1833);
            12:      val = ZW'(917);
            13:      val = ZW'(458);
            14:      val = ZW'(229);
            15:      val = ZW'(115);
            16:      val = ZW'(57);
            17:      val = ZW'(29);
            18:      val = ZW'(14);
            19:      val = ZW'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[design/c2p_if.sv]
// Stream interfaces for the point input and the polar result.
// Depends on c2p_pkg.
`default_nettype none

interface c2p_point_if import c2p_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_coord;
    logic signed [DATA_WIDTH-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_polar_if import c2p_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic        [DATA_WIDTH-1:0] radius;
    logic signed [ANGLE_W-1:0]    angle_deg;
    logic        [1:0]            quadrant;

    modport source (output valid, output radius, output angle_deg, output quadrant,
                    input ready);
    modport sink   (input valid, input radius, input angle_deg, input quadrant,
                    output ready);
endinterface

`default_nettype wire

[design/c2p_front.sv]
// Input stages: sign folding, quadrant flags, squares, then the square sum.
// Depends on c2p_pkg.
`default_nettype none

module c2p_front import c2p_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_up_valid,
    output logic                              o_up_ready,
    input  wire logic signed [DATA_WIDTH-1:0] i_x_coord,
    input  wire logic signed [DATA_WIDTH-1:0] i_y_coord,
    output logic                              o_dn_valid,
    input  wire logic                         i_dn_ready,
    output t_c2p_item                         o_dn_item
);

    logic signed [DATA_WIDTH:0] x_ext, y_ext, x_fold, y_fold, y_abs;
    logic        [DATA_WIDTH-1:0] ax, ay;
    logic        [NW-1:0]       sqx, sqy;
    t_c2p_flags                 flags;
    t_c2p_cordic                cinit;
    logic                       en_a, en_b;

    logic                       r_a_valid, r_b_valid;
    logic        [NW-1:0]       r_a_sqx, r_a_sqy;
    t_c2p_flags                 r_a_flags;
    t_c2p_cordic                r_a_cordic;
    t_c2p_item                  r_b_item, n_b_item;

    assign x_ext  = {i_x_coord[DATA_WIDTH-1], i_x_coord};
    assign y_ext  = {i_y_coord[DATA_WIDTH-1], i_y_coord};
    // negating both coordinates keeps y/x, so CORDIC always starts with x >= 0
    assign x_fold = i_x_coord[DATA_WIDTH-1] ? -x_ext : x_ext;
    assign y_fold = i_x_coord[DATA_WIDTH-1] ? -y_ext : y_ext;
    assign y_abs  = i_y_coord[DATA_WIDTH-1] ? -y_ext : y_ext;
    assign ax     = x_fold[DATA_WIDTH-1:0];
    assign ay     = y_abs[DATA_WIDTH-1:0];
    assign sqx    = NW'(ax) * NW'(ax);
    assign sqy    = NW'(ay) * NW'(ay);

    always_comb begin
        flags.x_zero = (i_x_coord == '0);
        flags.y_neg  = i_y_coord[DATA_WIDTH-1];
        flags.y_pos  = !i_y_coord[DATA_WIDTH-1] && (i_y_coord != '0);
        if (!flags.x_zero && !i_x_coord[DATA_WIDTH-1] && flags.y_pos) begin
            flags.quad = QUAD_FIRST;
        end else if (i_x_coord[DATA_WIDTH-1] && flags.y_pos) begin
            flags.quad = QUAD_SECOND;
        end else if (i_x_coord[DATA_WIDTH-1] && flags.y_neg) begin
            flags.quad = QUAD_THIRD;
        end else begin
            flags.quad = QUAD_OTHER;
        end
        cinit.cx = CW'(x_fold) <<< PRE_SHIFT;
        cinit.cy = CW'(y_fold) <<< PRE_SHIFT;
        cinit.z  = '0;
    end

    always_comb begin
        n_b_item.flags     = r_a_flags;
        n_b_item.cordic    = r_a_cordic;
        n_b_item.sqrt.n    = r_a_sqx + r_a_sqy;
        n_b_item.sqrt.rem  = '0;
        n_b_item.sqrt.root = '0;
    end

    assign en_b       = !r_b_valid || i_dn_ready;
    assign en_a       = !r_a_valid || en_b;
    assign o_up_ready = en_a;
    assign o_dn_valid = r_b_valid;
    assign o_dn_item  = r_b_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_up_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_up_valid) begin
            r_a_sqx    <= sqx;
            r_a_sqy    <= sqy;
            r_a_flags  <= flags;
            r_a_cordic <= cinit;
        end
        if (en_b && r_a_valid) begin
            r_b_item <= n_b_item;
        end
    end

endmodule

`default_nettype wire

[design/c2p_core.sv]
// Iteration pipeline: one CORDIC vectoring step per stage and one square-root
// digit in each of the first DATA_WIDTH stages, in lock-step lanes. Depends on c2p_pkg.
`default_nettype none

module c2p_core import c2p_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_up_valid,
    output logic           o_up_ready,
    input  wire t_c2p_item i_up_item,
    output logic           o_dn_valid,
    input  wire logic      i_dn_ready,
    output t_c2p_item      o_dn_item
);

    logic      [PIPE_STAGES:0] en;
    logic                      r_valid [PIPE_STAGES];
    t_c2p_item                 r_item  [PIPE_STAGES];

    assign en[PIPE_STAGES] = i_dn_ready;

    for (genvar s = 0; s < PIPE_STAGES; s++) begin : g_stage
        t_c2p_item            stage_in, n_item;
        logic                 in_valid;
        logic signed [CW-1:0] cx_in, cy_in, dx, dy;
        logic        [RW-1:0] rem_sh, trial;
        logic                 ge;

        if (s == 0) begin : g_head
            assign stage_in = i_up_item;
            assign in_valid = i_up_valid;
        end else begin : g_body
            assign stage_in = r_item[s-1];
            assign in_valid = r_valid[s-1];
        end

        assign en[s] = !r_valid[s] || en[s+1];

        assign cx_in  = stage_in.cordic.cx;
        assign cy_in  = stage_in.cordic.cy;
        assign dx     = cy_in >>> s;
        assign dy     = cx_in >>> s;
        assign rem_sh = {stage_in.sqrt.rem[RW-3:0], stage_in.sqrt.n[NW-1:NW-2]};
        assign trial  = {stage_in.sqrt.root, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_comb begin
            n_item = stage_in;
            if (s < CORDIC_STEPS) begin
                // rotate toward the x axis, sign of y picks the direction
                if (!cy_in[CW-1]) begin
                    n_item.cordic.cx = cx_in + dx;
                    n_item.cordic.cy = cy_in - dy;
                    n_item.cordic.z  = stage_in.cordic.z + atan_deg_q16(s);
                end else begin
                    n_item.cordic.cx = cx_in - dx;
                    n_item.cordic.cy = cy_in + dy;
                    n_item.cordic.z  = stage_in.cordic.z - atan_deg_q16(s);
                end
            end
            if (s < DATA_WIDTH) begin
                n_item.sqrt.n    = {stage_in.sqrt.n[NW-3:0], 2'b00};
                n_item.sqrt.rem  = ge ? (rem_sh - trial) : rem_sh;
                n_item.sqrt.root = {stage_in.sqrt.root[DATA_WIDTH-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (en[s]) begin
                r_valid[s] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s] && in_valid) begin
                r_item[s] <= n_item;
            end
        end
    end

    assign o_up_ready = en[0];
    assign o_dn_valid = r_valid[PIPE_STAGES-1];
    assign o_dn_item  = r_item[PIPE_STAGES-1];

endmodule

`default_nettype wire

[design/c2p_back.sv]
// Output stage: angle rounding and clamp, vertical-axis override, radius
// rounding; holds the result register. Depends on c2p_pkg.
`default_nettype none

module c2p_back import c2p_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_up_valid,
    output logic                          o_up_ready,
    input  wire t_c2p_item                i_up_item,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic        [DATA_WIDTH-1:0]  o_radius,
    output logic signed [ANGLE_W-1:0]     o_angle_deg,
    output logic        [1:0]             o_quadrant
);

    localparam int QW = ZW - 7;
    localparam logic signed [QW-1:0] LIM_POS = QW'(ANGLE_LIMIT);
    localparam logic signed [QW-1:0] LIM_NEG = -QW'(ANGLE_LIMIT);

    logic                         en;
    logic signed [ZW-1:0]         z;
    logic        [ZW-1:0]         z_mag, z_rnd;
    logic signed [QW-1:0]         q_mag, q, q_sat, n_angle_q;
    logic        [DATA_WIDTH:0]   root_rnd;
    logic        [DATA_WIDTH-1:0] n_radius;

    logic                         r_valid;
    logic        [DATA_WIDTH-1:0] r_radius;
    logic signed [ANGLE_W-1:0]    r_angle;
    logic        [1:0]            r_quad;

    always_comb begin
        z     = i_up_item.cordic.z;
        // Q.16 to Q.8, half away from zero
        z_mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
        z_rnd = z_mag + ZW'(128);
        q_mag = {1'b0, z_rnd[ZW-1:8]};
        q     = z[ZW-1] ? -q_mag : q_mag;
        if (q > LIM_POS) begin
            q_sat = LIM_POS;
        end else if (q < LIM_NEG) begin
            q_sat = LIM_NEG;
        end else begin
            q_sat = q;
        end
        // on the vertical axis the angle follows the sign of y alone
        if (i_up_item.flags.x_zero) begin
            if (i_up_item.flags.y_pos) begin
                n_angle_q = LIM_POS;
            end else if (i_up_item.flags.y_neg) begin
                n_angle_q = LIM_NEG;
            end else begin
                n_angle_q = '0;
            end
        end else begin
            n_angle_q = q_sat;
        end

        // round up when n - r^2 > r
        root_rnd = {1'b0, i_up_item.sqrt.root}
                 + (DATA_WIDTH+1)'(i_up_item.sqrt.rem > RW'(i_up_item.sqrt.root));
        n_radius = root_rnd[DATA_WIDTH] ? '1 : root_rnd[DATA_WIDTH-1:0];
    end

    assign en         = !r_valid || i_ready;
    assign o_up_ready = en;
    assign o_valid    = r_valid;
    assign o_radius   = r_radius;
    assign o_angle_deg = r_angle;
    assign o_quadrant = r_quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_up_valid) begin
            r_radius <= n_radius;
            r_angle  <= n_angle_q[ANGLE_W-1:0];
            r_quad   <= i_up_item.flags.quad;
        end
    end

endmodule

`default_nettype wire

[design/cartesian_to_polar_degrees_unit.sv]
// Top level of the cartesian-to-polar converter: front, iteration pipeline
// and output stage. Depends on c2p_pkg, c2p_if, c2p_front, c2p_core, c2p_back.
//
// Usage:
//   i_point carries one point (x_coord, y_coord), signed Q8.8. o_polar returns
//   radius (unsigned Q8.8, rounded), angle_deg (atan(y/x) in degrees, signed
//   Q7.8, -90..+90) and quadrant. A transaction completes on a rising edge
//   with valid and ready both high.
//   Pipeline: 23 register stages: two front stages (squares, then square sum),
//   20 iteration stages (one CORDIC step each, with one square-root digit in
//   each of the first DATA_WIDTH; the 20 CORDIC steps set the depth) and the
//   output register.
//   Throughput: one transaction per cycle, sustained while o_polar.ready is high.
//   Reset (i_rst_n low, synchronous) empties the pipeline; no payload is
//   cleared, no valid result appears until a new point is taken.
//   When the receiver holds o_polar.ready low the result stays on the output
//   and bubbles inside the pipeline are squeezed out; the input keeps taking
//   points until every stage is full, then i_point.ready drops.
`default_nettype none

module cartesian_to_polar_degrees_unit import c2p_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    c2p_point_if.sink   i_point,
    c2p_polar_if.source o_polar
);

    // front -> iteration pipeline
    logic      front_valid, front_ready;
    t_c2p_item front_item;
    // iteration pipeline -> output stage
    logic      core_valid, core_ready;
    t_c2p_item core_item;

    c2p_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (i_point.valid),
        .o_up_ready (i_point.ready),
        .i_x_coord  (i_point.x_coord),
        .i_y_coord  (i_point.y_coord),
        .o_dn_valid (front_valid),
        .i_dn_ready (front_ready),
        .o_dn_item  (front_item)
    );

    c2p_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (front_valid),
        .o_up_ready (front_ready),
        .i_up_item  (front_item),
        .o_dn_valid (core_valid),
        .i_dn_ready (core_ready),
        .o_dn_item  (core_item)
    );

    // result register sits here, so valid and the result reach the receiver from registers
    c2p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_up_valid  (core_valid),
        .o_up_ready  (core_ready),
        .i_up_item   (core_item),
        .o_valid     (o_polar.valid),
        .i_ready     (o_polar.ready),
        .o_radius    (o_polar.radius),
        .o_angle_deg (o_polar.angle_deg),
        .o_quadrant  (o_polar.quadrant)
    );

endmodule

`default_nettype wire

[design/c2p_checker.sv]
// Port-level checks on the converter's result channel, bound to the top level.
// Depends on c2p_pkg and cartesian_to_polar_degrees_unit.
`default_nettype none

module c2p_checker import c2p_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_ready,
    input wire logic        [DATA_WIDTH-1:0] i_radius,
    input wire logic signed [ANGLE_W-1:0]    i_angle_deg,
    input wire logic        [1:0]            i_quadrant
);

    localparam logic signed [ANGLE_W-1:0] LIM_POS = ANGLE_W'(ANGLE_LIMIT);
    localparam logic signed [ANGLE_W-1:0] LIM_NEG = -ANGLE_W'(ANGLE_LIMIT);

    // pipeline is empty the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_angle_deg <= LIM_POS) && (i_angle_deg >= LIM_NEG))
        else $error("angle outside +-90 degrees");

    // off-axis points in the first three quadrants have a nonzero magnitude
    a_radius_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_quadrant != QUAD_OTHER) |-> (i_radius != '0))
        else $error("zero radius for a point off the axes");

    // first and third quadrants give y/x > 0, second gives y/x < 0
    a_angle_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (((i_quadrant == QUAD_FIRST) || (i_quadrant == QUAD_THIRD)) ? !i_angle_deg[ANGLE_W-1]
           : ((i_quadrant == QUAD_SECOND) ? (i_angle_deg <= 0) : 1'b1)))
        else $error("angle sign does not match quadrant");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_radius) && $stable(i_angle_deg) && $stable(i_quadrant))
        else $error("stalled result changed");

endmodule

bind cartesian_to_polar_degrees_unit c2p_checker u_c2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_polar.valid),
    .i_out_ready (o_polar.ready),
    .i_radius    (o_polar.radius),
    .i_angle_deg (o_polar.angle_deg),
    .i_quadrant  (o_polar.quadrant)
);

`default_nettype wire
